>>> rtl/ahob_pkg.sv
package ahob_pkg;

    localparam int OUTPUT_WIDTH = 24;

    // Item kinds on the input channel.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Width of the tanh numerator and denominator terms.
    localparam int TW = 44;

    // Rational tanh coefficients, already in Q.16.
    localparam logic [TW-1:0] K_N378    = TW'(64'd378    << 16);
    localparam logic [TW-1:0] K_N17325  = TW'(64'd17325  << 16);
    localparam logic [TW-1:0] K_135135  = TW'(64'd135135 << 16);
    localparam logic [TW-1:0] K_D3150   = TW'(64'd3150   << 16);
    localparam logic [TW-1:0] K_D62370  = TW'(64'd62370  << 16);

    typedef struct packed {
        logic        kind;
        logic [31:0] phase_increment;
        logic        octave_down;
        logic [6:0]  harmonic_index;
        logic [15:0] weight_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUTPUT_WIDTH-1:0] even_sample;
        logic signed [OUTPUT_WIDTH-1:0] odd_sample;
    } t_out_item;

endpackage

>>> rtl/additive_harmonic_oscillator_bank_top.sv
// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_stall      | i_in_data  (ahob_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall    | o_out_data (ahob_pkg::t_out_item)
//
// A tick transaction sweeps one harmonic per cycle through the phase and weight RAMs, then
// shapes the even and the odd sum one after the other on a shared bit-serial multiplier and
// a restoring divider. A sum that saturates skips the remaining shaping steps.
// A finished pair is held until the next accepted tick loads it into the output register,
// where it sits until it is taken.
// Reset is synchronous and active low; phases and weights read as zero until written.
// The input stalls while a tick is being worked on, and also while a result still waits
// on a stalled output.
module additive_harmonic_oscillator_bank_top #(
    parameter int HARMONICS       = 128,
    parameter int SINE_TABLE_SIZE = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ahob_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ahob_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    localparam int HB   = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int CW   = HB + 1;
    localparam int RB   = $clog2(SINE_TABLE_SIZE + 1) - 1;
    localparam int TS   = 1 << RB;
    localparam int MW   = RB + 4;
    localparam int OW   = ahob_pkg::OUTPUT_WIDTH;
    localparam int FRAC = OW - 1;
    localparam int NW   = $clog2(FRAC + 1);
    localparam int TW   = ahob_pkg::TW;
    localparam int DW   = TW - 10;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [FRAC:0] OUT_MAX = {1'b0, {FRAC{1'b1}}};
    localparam logic [FRAC:0] OUT_NEG = {1'b1, {FRAC{1'b0}}};

    typedef logic signed [15:0] t_sine_tab [TS];

    // Sine of theta (Q2.30, first quadrant) scaled to 0..32767 by a Taylor series.
    function automatic logic [15:0] quarter_sine(input logic [63:0] theta);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        t2   = (theta * theta) >> 30;
        term = theta;
        sum  = theta;
        for (int n = 1; n <= 6; n++) begin
            term = (term * t2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sum = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (sum > 64'd32767) begin
            sum = 64'd32767;
        end
        return sum[15:0];
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] h;
        logic [63:0] q;
        logic [15:0] v;
        for (int s = 0; s < TS; s++) begin
            h = 64'(s) & 64'(TS / 2 - 1);
            q = (h <= 64'(TS / 4)) ? h : 64'(TS / 2) - h;
            v = quarter_sine((q * TWO_PI_Q30) >> RB);
            tab[s] = (s >= TS / 2) ? -$signed(v) : $signed(v);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_NEXT
    } t_state;

    t_state r_state;

    // Sweep control.
    logic [31:0]    r_inc;
    logic [31:0]    r_mult;
    logic [CW-1:0]  r_idx;
    logic [MW-1:0]  r_m9;
    logic [MW-1:0]  r_step9;
    logic           r_issue;
    logic [HARMONICS-1:0] r_pvalid;
    logic [HARMONICS-1:0] r_wvalid;

    // Sweep pipeline stages.
    logic           r_s1_v, r_s2_v, r_s3_v;
    logic [HB-1:0]  r_s1_idx;
    logic [31:0]    r_s1_mult;
    logic           r_s1_pv, r_s1_wv;
    logic           r_s2_odd, r_s3_odd;
    logic [15:0]    r_s2_w;
    logic signed [15:0] r_sine;
    logic signed [32:0] r_prod;
    logic signed [39:0] r_acc_even, r_acc_odd;

    // Shaper.
    logic           r_ch;
    logic           r_neg;
    logic           r_sat;
    logic [18:0]    r_x;
    logic [21:0]    r_x2;
    logic [TW-1:0]  r_a;
    logic [2:0]     r_step;
    logic [65:0]    r_ma;
    logic [21:0]    r_mb;
    logic [65:0]    r_mp;
    logic [DW-1:0]  r_rem, r_den;
    logic [FRAC:0]  r_q;
    logic [NW-1:0]  r_cnt;
    logic [OW-1:0]  r_res_even;
    logic [OW-1:0]  r_pend_even, r_pend_odd;

    logic           r_out_valid;
    ahob_pkg::t_out_item r_out;

    // Combinational helpers.
    logic           in_acc;
    logic [31:0]    n_inc;
    logic [RB-1:0]  n_step;
    logic           n_run;
    logic [31:0]    ph_rdata;
    logic [15:0]    w_rdata;
    logic [31:0]    n_phase;
    logic [31:0]    ph_old;
    logic [15:0]    w_cur;
    logic signed [39:0] acc_sel;
    logic [39:0]    n_mag;
    logic [24:0]    n_xfull;
    logic [TW-1:0]  ph;
    logic [TW-1:0]  n_b;
    logic [DW-1:0]  n_rem0;
    logic [DW:0]    rem2;
    logic           dbit;
    logic [FRAC:0]  n_y;
    logic [OW-1:0]  n_res;
    logic [TW-1:0]  x2w;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);

    assign n_inc  = i_in_data.octave_down ? (i_in_data.phase_increment >> 1)
                                          : i_in_data.phase_increment;
    assign n_step = n_inc[31 -: RB];

    // Harmonic i runs while i < HARMONICS and 9*step*(i+1) <= 4*table size.
    assign n_run = (r_state == ST_SWEEP) && r_issue && (r_idx < CW'(HARMONICS))
                   && (r_m9 <= MW'(4 * TS));

    assign ph_old  = r_s1_pv ? ph_rdata : 32'd0;
    assign w_cur   = r_s1_wv ? w_rdata : 16'd0;
    assign n_phase = ph_old + r_s1_mult;

    ahob_ram #(.WIDTH(32), .DEPTH(HARMONICS)) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_idx),
        .i_wdata (n_phase),
        .i_raddr (r_idx[HB-1:0]),
        .o_rdata (ph_rdata)
    );

    ahob_ram #(.WIDTH(16), .DEPTH(HARMONICS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_in_data.kind == ahob_pkg::KIND_WRITE
                  && 32'(i_in_data.harmonic_index) < HARMONICS),
        .i_waddr (HB'(i_in_data.harmonic_index)),
        .i_wdata (i_in_data.weight_value),
        .i_raddr (r_idx[HB-1:0]),
        .o_rdata (w_rdata)
    );

    assign acc_sel = r_ch ? r_acc_odd : r_acc_even;
    assign n_mag   = acc_sel[39] ? 40'(-acc_sel) : 40'(acc_sel);
    assign n_xfull = n_mag[39:15];
    assign ph      = TW'(r_mp >> 16);
    assign n_b     = ahob_pkg::K_135135 + ph;
    assign n_rem0  = r_a[TW-1:10];
    assign rem2    = {r_rem, 1'b0};
    assign dbit    = rem2 >= {1'b0, r_den};
    assign x2w     = TW'(r_x2);

    always_comb begin
        if (r_sat) begin
            n_y = r_neg ? OUT_NEG : OUT_MAX;
        end else begin
            n_y = r_q;
        end
        if (!r_neg && n_y > OUT_MAX) begin
            n_y = OUT_MAX;
        end
        n_res = r_neg ? OW'(-n_y) : OW'(n_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= 1'b0;
            r_idx       <= '0;
            r_pvalid    <= '0;
            r_wvalid    <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_pend_even <= '0;
            r_pend_odd  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // An accepted tick loads the output register; otherwise a taken
            // result empties it.
            if (in_acc && i_in_data.kind == ahob_pkg::KIND_TICK) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Sweep pipeline, advancing every cycle.
            r_s1_v <= n_run;
            if (n_run) begin
                r_s1_idx  <= r_idx[HB-1:0];
                r_s1_mult <= r_mult;
                r_s1_pv   <= r_pvalid[r_idx[HB-1:0]];
                r_s1_wv   <= r_wvalid[r_idx[HB-1:0]];
                r_idx     <= r_idx + CW'(1);
                r_mult    <= r_mult + r_inc;
                r_m9      <= r_m9 + r_step9;
            end
            r_s2_v <= r_s1_v;
            if (r_s1_v) begin
                r_pvalid[r_s1_idx] <= 1'b1;
                r_sine   <= SINE_TAB[n_phase[31 -: RB]];
                r_s2_w   <= w_cur;
                r_s2_odd <= r_s1_idx[0];
            end
            r_s3_v <= r_s2_v;
            if (r_s2_v) begin
                r_prod   <= r_sine * $signed({1'b0, r_s2_w});
                r_s3_odd <= r_s2_odd;
            end
            if (r_s3_v) begin
                if (r_s3_odd) begin
                    r_acc_odd <= r_acc_odd + 40'(r_prod);
                end else begin
                    r_acc_even <= r_acc_even + 40'(r_prod);
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.kind == ahob_pkg::KIND_WRITE) begin
                            if (32'(i_in_data.harmonic_index) < HARMONICS) begin
                                r_wvalid[HB'(i_in_data.harmonic_index)] <= 1'b1;
                            end
                        end else begin
                            r_out.even_sample <= r_pend_even;
                            r_out.odd_sample  <= r_pend_odd;
                            r_inc       <= n_inc;
                            r_mult      <= n_inc;
                            r_idx       <= '0;
                            r_step9     <= MW'(n_step) * MW'(9);
                            r_m9        <= MW'(n_step) * MW'(9);
                            r_issue     <= 1'b1;
                            r_acc_even  <= '0;
                            r_acc_odd   <= '0;
                            r_state     <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (!n_run) begin
                        r_issue <= 1'b0;
                        if (!r_s1_v && !r_s2_v && !r_s3_v) begin
                            r_ch    <= 1'b0;
                            r_state <= ST_ABS;
                        end
                    end
                end
                ST_ABS: begin
                    r_neg <= acc_sel[39];
                    if (n_xfull[24:19] != '0) begin
                        r_sat   <= 1'b1;
                        r_state <= ST_NEXT;
                    end else begin
                        r_sat   <= 1'b0;
                        r_x     <= n_xfull[18:0];
                        r_ma    <= 66'(n_xfull[18:0]);
                        r_mb    <= 22'(n_xfull[18:0]);
                        r_mp    <= '0;
                        r_step  <= 3'd0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_mb != '0) begin
                        if (r_mb[0]) begin
                            r_mp <= r_mp + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end else begin
                        r_mp <= '0;
                        case (r_step)
                            3'd0: begin
                                r_x2 <= ph[21:0];
                                r_ma <= 66'(ahob_pkg::K_N378 + TW'(ph[21:0]));
                                r_mb <= ph[21:0];
                            end
                            3'd1: begin
                                r_ma <= 66'(ahob_pkg::K_N17325 + ph);
                                r_mb <= r_x2;
                            end
                            3'd2: begin
                                r_ma <= 66'(ahob_pkg::K_135135 + ph);
                                r_mb <= 22'(r_x);
                            end
                            3'd3: begin
                                r_a  <= ph;
                                r_ma <= 66'(ahob_pkg::K_D3150 + (x2w << 5) - (x2w << 2));
                                r_mb <= r_x2;
                            end
                            3'd4: begin
                                r_ma <= 66'(ahob_pkg::K_D62370 + ph);
                                r_mb <= r_x2;
                            end
                            default: begin
                                if (r_a >= n_b) begin
                                    r_sat   <= 1'b1;
                                    r_state <= ST_NEXT;
                                end else begin
                                    r_den <= n_b[TW-1:10];
                                    if (n_rem0 >= n_b[TW-1:10]) begin
                                        r_rem <= n_rem0 - n_b[TW-1:10];
                                        r_q   <= (FRAC + 1)'(1);
                                    end else begin
                                        r_rem <= n_rem0;
                                        r_q   <= '0;
                                    end
                                    r_cnt   <= NW'(FRAC);
                                    r_state <= ST_DIV;
                                end
                            end
                        endcase
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_DIV: begin
                    r_rem <= dbit ? DW'(rem2 - {1'b0, r_den}) : DW'(rem2);
                    r_q   <= {r_q[FRAC-1:0], dbit};
                    r_cnt <= r_cnt - NW'(1);
                    if (r_cnt == NW'(1)) begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (!r_ch) begin
                        r_res_even <= n_res;
                        r_ch       <= 1'b1;
                        r_state    <= ST_ABS;
                    end else begin
                        r_pend_even <= r_res_even;
                        r_pend_odd  <= n_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The multiply-accumulate pipeline only carries work during a sweep.
    a_pipe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> r_state == ST_SWEEP)
        else $error("sweep pipeline active outside the sweep");

    // The harmonic counter never runs past the bank.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CW'(HARMONICS))
        else $error("harmonic index out of range");

    // The divider keeps its partial remainder below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_den)
        else $error("divider remainder not reduced");

    // Finishing the odd channel returns the block to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEXT && r_ch) |=> r_state == ST_IDLE)
        else $error("shaper did not finish");

endmodule

>>> rtl/ahob_ram.sv
module ahob_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
